FILE: rtl/core/min_cross_xor_at_top_differing_bit_assert.svh
// Assertion macros used by the checker.
`ifndef MIN_CROSS_XOR_AT_TOP_DIFFERING_BIT_ASSERT_SVH
`define MIN_CROSS_XOR_AT_TOP_DIFFERING_BIT_ASSERT_SVH

// Same-cycle implication.
`define MCX_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MCX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mcx_pkg.sv
package mcx_pkg;

  localparam int VALUE_W   = 32;
  localparam int MAX_ITEMS = 1024;
  localparam int ADDR_W    = $clog2(MAX_ITEMS);
  localparam int CELLS     = 8;
  localparam int CNT_W     = $clog2(MAX_ITEMS + CELLS + 1);
  localparam int DR_W      = $clog2(CELLS + 2);

  typedef enum logic [2:0] {
    S_LOAD,
    S_PREP,
    S_FILL,
    S_SCAN,
    S_DRAIN,
    S_REDUCE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic shift;
    logic reduce;
  } cell_ctrl_t;

  // one-hot of the highest set bit
  function automatic logic [VALUE_W-1:0] top_onehot(input logic [VALUE_W-1:0] d);
    logic [VALUE_W-1:0] s;
    s = d;
    for (int i = 0; i < $clog2(VALUE_W); i++) begin
      s = s | (s >> (1 << i));
    end
    return d & ~(s >> 1);
  endfunction

endpackage

FILE: rtl/core/mcx_ram.sv
module mcx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/mcx_cell.sv
module mcx_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  mcx_pkg::cell_ctrl_t        ctrl,
  input  logic [mcx_pkg::VALUE_W-1:0] topmask,
  input  logic [mcx_pkg::VALUE_W-1:0] held_in,
  input  logic                       hv_in,
  input  logic [mcx_pkg::VALUE_W-1:0] s_in,
  input  logic                       sv_in,
  input  logic [mcx_pkg::VALUE_W-1:0] best_in,
  output logic [mcx_pkg::VALUE_W-1:0] held_out,
  output logic                       hv_out,
  output logic [mcx_pkg::VALUE_W-1:0] s_out,
  output logic                       sv_out,
  output logic [mcx_pkg::VALUE_W-1:0] best_out
);
  import mcx_pkg::*;

  logic [VALUE_W-1:0] held;
  logic               hv;
  logic [VALUE_W-1:0] s;
  logic               sv;
  logic [VALUE_W-1:0] best;
  logic [VALUE_W-1:0] x;
  logic               hit;

  assign x   = held ^ s;
  assign hit = sv && hv && ((x & topmask) != '0) && (x < best);

  always_ff @(posedge clk) begin
    if (rst) begin
      hv <= 1'b0;
      sv <= 1'b0;
    end else begin
      sv <= sv_in;
      if (ctrl.shift) begin
        hv <= hv_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    s <= s_in;
    if (ctrl.shift) begin
      held <= held_in;
    end
    if (ctrl.clr) begin
      best <= '1;
    end else if (ctrl.reduce) begin
      if (best_in < best) begin
        best <= best_in;
      end
    end else if (hit) begin
      best <= x;
    end
  end

  assign held_out = held;
  assign hv_out   = hv;
  assign s_out    = s;
  assign sv_out   = sv;
  assign best_out = best;

endmodule

FILE: rtl/core/min_cross_xor_at_top_differing_bit.sv
// Load: one beat per cycle, s_tready high while loading; a waiting result does not stall it.
// Solve after the last beat, n = stored count: when n >= 2 and the values differ, the
// 8-cell compare chain streams the value RAM once per block of 8; otherwise it is skipped.
// The final solve state waits while an earlier result is unaccepted.
// Result appears on m_tvalid the cycle after the solve, then loading resumes.
// rst (sync, active high) empties the set; the value RAM is not cleared.
module min_cross_xor_at_top_differing_bit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [mcx_pkg::VALUE_W-1:0] s_tdata,   // [31:0] value
  input  logic                        s_tlast,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [mcx_pkg::VALUE_W-1:0] m_tdata    // [31:0] min_xor
);
  import mcx_pkg::*;

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [VALUE_W-1:0] and_acc, and_next;
  logic [VALUE_W-1:0] or_acc, or_next;
  logic [VALUE_W-1:0] topmask, topmask_next;
  logic [CNT_W-1:0]   base, base_next;
  logic [CNT_W-1:0]   idx, idx_next;
  logic [DR_W-1:0]    cnt, cnt_next;
  logic [VALUE_W-1:0] res, res_next;
  logic               m_tvalid_next;
  logic [VALUE_W-1:0] m_tdata_next;
  logic               shift_d, fvalid_d, scan_d;
  logic               rd_fill, rd_scan;
  logic [CNT_W-1:0]   rd_addr;
  logic [CNT_W-1:0]   base_step;
  logic [VALUE_W-1:0] diff;
  logic               we;
  logic [VALUE_W-1:0] rdata;
  cell_ctrl_t         ctrl, ctrl_comb;

  logic [VALUE_W-1:0] held_c [CELLS+1];
  logic               hv_c   [CELLS+1];
  logic [VALUE_W-1:0] s_c    [CELLS+1];
  logic               sv_c   [CELLS+1];
  logic [VALUE_W-1:0] best_c [CELLS+1];

  assign diff      = or_acc ^ and_acc;
  assign base_step = base + CNT_W'(CELLS);

  always_comb begin
    state_next    = state;
    count_next    = count;
    and_next      = and_acc;
    or_next       = or_acc;
    topmask_next  = topmask;
    base_next     = base;
    idx_next      = idx;
    cnt_next      = cnt;
    res_next      = res;
    m_tvalid_next = m_tvalid && !m_tready;
    m_tdata_next  = m_tdata;
    s_tready      = 1'b0;
    we            = 1'b0;
    rd_fill       = 1'b0;
    rd_scan       = 1'b0;
    rd_addr       = base + idx;
    ctrl_comb     = '0;
    unique case (state)
      S_LOAD: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (count < CNT_W'(MAX_ITEMS)) begin
            we         = 1'b1;
            count_next = count + CNT_W'(1);
            and_next   = and_acc & s_tdata;
            or_next    = or_acc | s_tdata;
          end
          if (s_tlast) begin
            state_next = S_PREP;
          end
        end
      end
      S_PREP: begin
        topmask_next  = top_onehot(diff);
        ctrl_comb.clr = 1'b1;
        base_next     = '0;
        idx_next      = '0;
        if (count < CNT_W'(2) || diff == '0) begin
          res_next   = '0;
          state_next = S_DONE;
        end else begin
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        rd_fill = 1'b1;
        if (idx == CNT_W'(CELLS - 1)) begin
          idx_next   = '0;
          state_next = S_SCAN;
        end else begin
          idx_next = idx + CNT_W'(1);
        end
      end
      S_SCAN: begin
        rd_addr = idx;
        rd_scan = 1'b1;
        if (idx == count - CNT_W'(1)) begin
          cnt_next   = '0;
          state_next = S_DRAIN;
        end else begin
          idx_next = idx + CNT_W'(1);
        end
      end
      S_DRAIN: begin
        if (cnt == DR_W'(CELLS)) begin
          cnt_next  = '0;
          base_next = base_step;
          if (base_step < count) begin
            idx_next   = '0;
            state_next = S_FILL;
          end else begin
            state_next = S_REDUCE;
          end
        end else begin
          cnt_next = cnt + DR_W'(1);
        end
      end
      S_REDUCE: begin
        ctrl_comb.reduce = 1'b1;
        if (cnt == DR_W'(CELLS - 1)) begin
          res_next   = best_c[CELLS];
          state_next = S_DONE;
        end else begin
          cnt_next = cnt + DR_W'(1);
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tvalid_next = 1'b1;
          m_tdata_next  = res;
          count_next    = '0;
          and_next      = '1;
          or_next       = '0;
          state_next    = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      count    <= '0;
      and_acc  <= '1;
      or_acc   <= '0;
      base     <= '0;
      idx      <= '0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
      shift_d  <= 1'b0;
      fvalid_d <= 1'b0;
      scan_d   <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      and_acc  <= and_next;
      or_acc   <= or_next;
      base     <= base_next;
      idx      <= idx_next;
      cnt      <= cnt_next;
      m_tvalid <= m_tvalid_next;
      shift_d  <= rd_fill;
      fvalid_d <= rd_fill && (rd_addr < count);
      scan_d   <= rd_scan;
    end
  end

  always_ff @(posedge clk) begin
    topmask <= topmask_next;
    res     <= res_next;
    m_tdata <= m_tdata_next;
  end

  // fill shift lines up with the registered RAM read
  always_comb begin
    ctrl       = ctrl_comb;
    ctrl.shift = shift_d;
  end

  mcx_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(MAX_ITEMS)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(count[ADDR_W-1:0]),
    .wdata(s_tdata),
    .raddr(rd_addr[ADDR_W-1:0]),
    .rdata(rdata)
  );

  assign held_c[0] = rdata;
  assign hv_c[0]   = fvalid_d;
  assign s_c[0]    = rdata;
  assign sv_c[0]   = scan_d;
  assign best_c[0] = '1;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    mcx_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .topmask (topmask),
      .held_in (held_c[k]),
      .hv_in   (hv_c[k]),
      .s_in    (s_c[k]),
      .sv_in   (sv_c[k]),
      .best_in (best_c[k]),
      .held_out(held_c[k+1]),
      .hv_out  (hv_c[k+1]),
      .s_out   (s_c[k+1]),
      .sv_out  (sv_c[k+1]),
      .best_out(best_c[k+1])
    );
  end

endmodule

FILE: rtl/core/mcx_checker.sv
`include "min_cross_xor_at_top_differing_bit_assert.svh"

module mcx_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic                        s_tlast,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [mcx_pkg::VALUE_W-1:0] m_tdata
);

  `MCX_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat dropped or changed while stalled")

  `MCX_ASSERT_NEXT(a_busy_after_last, clk, rst, s_tvalid && s_tready && s_tlast, !s_tready, "input taken right after the last beat of a set")

  `MCX_ASSERT_NOW(a_result_after_solve, clk, rst, $rose(m_tvalid), !$past(s_tready), "result appeared while loading")

  `MCX_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, !m_tvalid && s_tready, "block not idle after reset")

endmodule

bind min_cross_xor_at_top_differing_bit mcx_checker u_mcx_checker (.*);
